FILE: rtl/core/otl_pkg.sv
// Package for the operator token lexer: token codes, prefix states,
// character constants and the per-byte lexing function.
// Depends on nothing; imported by otl_step and operator_token_lexer.
package otl_pkg;

  typedef enum logic [5:0] {
    TK_NOT, TK_NE, TK_SNE, TK_MOD, TK_MOD_EQ, TK_AND, TK_LAND, TK_AND_EQ,
    TK_LPAREN, TK_RPAREN, TK_MUL, TK_MUL_EQ, TK_ADD, TK_INC, TK_ADD_EQ,
    TK_COMMA, TK_SUB, TK_DEC, TK_SUB_EQ, TK_DOT, TK_DIV, TK_DIV_EQ,
    TK_COLON, TK_LT, TK_SHL, TK_SHL_EQ, TK_LE, TK_ASSIGN, TK_EQ, TK_SEQ,
    TK_GT, TK_GE, TK_SHR, TK_SHR_EQ, TK_SHRU, TK_SHRU_EQ, TK_QUEST,
    TK_LBRACK, TK_RBRACK, TK_XOR, TK_XOR_EQ, TK_LBRACE, TK_OR, TK_OR_EQ,
    TK_LOR, TK_RBRACE, TK_TILDE, TK_INVALID
  } tok_t;

  typedef enum logic [4:0] {
    PS_IDLE, PS_NOT, PS_NE, PS_MOD, PS_AND, PS_MUL, PS_ADD, PS_SUB, PS_DIV,
    PS_LT, PS_SHL, PS_EQ, PS_EQEQ, PS_GT, PS_SHR, PS_SHRU, PS_XOR, PS_OR
  } prefix_t;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef struct packed {
    logic    hit;
    tok_t    code;
    prefix_t nxt;
  } lex_t;

  typedef struct packed {
    logic       emit;
    tok_t       code;
    logic       ret;
    logic [7:0] bad;
  } step_t;

  function automatic tok_t pending_code(prefix_t s);
    tok_t t;
    case (s)
      PS_NOT:  t = TK_NOT;
      PS_NE:   t = TK_NE;
      PS_MOD:  t = TK_MOD;
      PS_AND:  t = TK_AND;
      PS_MUL:  t = TK_MUL;
      PS_ADD:  t = TK_ADD;
      PS_SUB:  t = TK_SUB;
      PS_DIV:  t = TK_DIV;
      PS_LT:   t = TK_LT;
      PS_SHL:  t = TK_SHL;
      PS_EQ:   t = TK_ASSIGN;
      PS_EQEQ: t = TK_EQ;
      PS_GT:   t = TK_GT;
      PS_SHR:  t = TK_SHR;
      PS_SHRU: t = TK_SHRU;
      PS_XOR:  t = TK_XOR;
      PS_OR:   t = TK_OR;
      default: t = TK_NOT;
    endcase
    return t;
  endfunction

  function automatic lex_t lex_byte(prefix_t s, logic [7:0] c);
    lex_t r;
    r.hit  = 1'b1;
    r.code = TK_INVALID;
    r.nxt  = PS_IDLE;
    case (s)
      PS_IDLE: begin
        case (c)
          CH_BANG:   begin r.code = TK_NOT;    r.nxt = PS_NOT; end
          CH_PCT:    begin r.code = TK_MOD;    r.nxt = PS_MOD; end
          CH_AMP:    begin r.code = TK_AND;    r.nxt = PS_AND; end
          CH_LPAREN: r.code = TK_LPAREN;
          CH_RPAREN: r.code = TK_RPAREN;
          CH_STAR:   begin r.code = TK_MUL;    r.nxt = PS_MUL; end
          CH_PLUS:   begin r.code = TK_ADD;    r.nxt = PS_ADD; end
          CH_COMMA:  r.code = TK_COMMA;
          CH_MINUS:  begin r.code = TK_SUB;    r.nxt = PS_SUB; end
          CH_DOT:    r.code = TK_DOT;
          CH_SLASH:  begin r.code = TK_DIV;    r.nxt = PS_DIV; end
          CH_COLON:  r.code = TK_COLON;
          CH_LT:     begin r.code = TK_LT;     r.nxt = PS_LT; end
          CH_EQ:     begin r.code = TK_ASSIGN; r.nxt = PS_EQ; end
          CH_GT:     begin r.code = TK_GT;     r.nxt = PS_GT; end
          CH_QUEST:  r.code = TK_QUEST;
          CH_LBRACK: r.code = TK_LBRACK;
          CH_RBRACK: r.code = TK_RBRACK;
          CH_CARET:  begin r.code = TK_XOR;    r.nxt = PS_XOR; end
          CH_LBRACE: r.code = TK_LBRACE;
          CH_BAR:    begin r.code = TK_OR;     r.nxt = PS_OR; end
          CH_RBRACE: r.code = TK_RBRACE;
          CH_TILDE:  r.code = TK_TILDE;
          default:   r.hit = 1'b0;
        endcase
      end
      PS_NOT: begin
        if (c == CH_EQ) begin r.code = TK_NE; r.nxt = PS_NE; end
        else r.hit = 1'b0;
      end
      PS_NE: begin
        if (c == CH_EQ) r.code = TK_SNE;
        else r.hit = 1'b0;
      end
      PS_MOD: begin
        if (c == CH_EQ) r.code = TK_MOD_EQ;
        else r.hit = 1'b0;
      end
      PS_AND: begin
        if (c == CH_AMP) r.code = TK_LAND;
        else if (c == CH_EQ) r.code = TK_AND_EQ;
        else r.hit = 1'b0;
      end
      PS_MUL: begin
        if (c == CH_EQ) r.code = TK_MUL_EQ;
        else r.hit = 1'b0;
      end
      PS_ADD: begin
        if (c == CH_PLUS) r.code = TK_INC;
        else if (c == CH_EQ) r.code = TK_ADD_EQ;
        else r.hit = 1'b0;
      end
      PS_SUB: begin
        if (c == CH_MINUS) r.code = TK_DEC;
        else if (c == CH_EQ) r.code = TK_SUB_EQ;
        else r.hit = 1'b0;
      end
      PS_DIV: begin
        if (c == CH_EQ) r.code = TK_DIV_EQ;
        else r.hit = 1'b0;
      end
      PS_LT: begin
        if (c == CH_LT) begin r.code = TK_SHL; r.nxt = PS_SHL; end
        else if (c == CH_EQ) r.code = TK_LE;
        else r.hit = 1'b0;
      end
      PS_SHL: begin
        if (c == CH_EQ) r.code = TK_SHL_EQ;
        else r.hit = 1'b0;
      end
      PS_EQ: begin
        if (c == CH_EQ) begin r.code = TK_EQ; r.nxt = PS_EQEQ; end
        else r.hit = 1'b0;
      end
      PS_EQEQ: begin
        if (c == CH_EQ) r.code = TK_SEQ;
        else r.hit = 1'b0;
      end
      PS_GT: begin
        if (c == CH_GT) begin r.code = TK_SHR; r.nxt = PS_SHR; end
        else if (c == CH_EQ) r.code = TK_GE;
        else r.hit = 1'b0;
      end
      PS_SHR: begin
        if (c == CH_GT) begin r.code = TK_SHRU; r.nxt = PS_SHRU; end
        else if (c == CH_EQ) r.code = TK_SHR_EQ;
        else r.hit = 1'b0;
      end
      PS_SHRU: begin
        if (c == CH_EQ) r.code = TK_SHRU_EQ;
        else r.hit = 1'b0;
      end
      PS_XOR: begin
        if (c == CH_EQ) r.code = TK_XOR_EQ;
        else r.hit = 1'b0;
      end
      PS_OR: begin
        if (c == CH_BAR) r.code = TK_LOR;
        else if (c == CH_EQ) r.code = TK_OR_EQ;
        else r.hit = 1'b0;
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/otl_step.sv
// Combinational lexing step: from the current prefix state and one input
// byte or flush, forms the next prefix state and the optional result.
// Depends on otl_pkg.
module otl_step (
  input  otl_pkg::prefix_t state_i,
  input  logic [7:0]       char_i,
  input  logic             flush_i,
  output otl_pkg::prefix_t state_nxt,
  output otl_pkg::step_t   step_o
);
  import otl_pkg::*;

  lex_t lx;

  assign lx = lex_byte(state_i, char_i);

  always_comb begin
    if (flush_i || !lx.hit) begin
      state_nxt = PS_IDLE;
    end else begin
      state_nxt = lx.nxt;
    end
  end

  always_comb begin
    step_o.emit = 1'b0;
    step_o.code = lx.code;
    step_o.ret  = 1'b0;
    step_o.bad  = 8'd0;
    if (flush_i) begin
      step_o.emit = (state_i != PS_IDLE);
      step_o.code = pending_code(state_i);
    end else if (!lx.hit) begin
      step_o.emit = 1'b1;
      if (state_i == PS_IDLE) begin
        step_o.code = TK_INVALID;
        step_o.bad  = char_i;
      end else begin
        step_o.code = pending_code(state_i);
        step_o.ret  = 1'b1;
      end
    end else begin
      step_o.emit = (lx.nxt == PS_IDLE);
    end
  end

endmodule

FILE: rtl/core/operator_token_lexer.sv
// Top level of the operator token lexer: input register, prefix state,
// result register and the valid/ready handshakes of both channels.
// Depends on otl_pkg and otl_step.
//
// Usage: each input transaction carries one source byte (in_char_byte) or
// an end-of-input mark (in_flush). Result transactions carry a token code,
// 0 to 46 for the operators in order and 47 for an invalid character, plus
// byte_returned, which tells the driver to present that byte again, and
// the offending byte for invalid characters.
// Bytes that only start or extend a prefix produce no result.
// One byte is accepted every cycle unless the held byte makes a result
// while the result register is stalled; the prefix update and the result
// are formed combinationally between the input and result registers.
// When the receiver stalls with a result waiting, the input register holds
// the next byte and in_ready drops only if that byte also makes a result;
// bytes that make no result keep flowing.
// Reset clears both registers' valid flags and returns the prefix to idle.
module operator_token_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_flush,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_token_code,
  output logic       out_byte_returned,
  output logic [7:0] out_bad_byte
);
  import otl_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_flush_r;
  prefix_t    prefix_r;
  prefix_t    prefix_nxt;
  step_t      step;
  logic       out_valid_r;
  tok_t       out_code_r;
  logic       out_ret_r;
  logic [7:0] out_bad_r;
  logic       out_free;
  logic       s1_adv;

  otl_step u_step (
    .state_i   (prefix_r),
    .char_i    (s1_char_r),
    .flush_i   (s1_flush_r),
    .state_nxt (prefix_nxt),
    .step_o    (step)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!step.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_byte;
      s1_flush_r <= in_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= PS_IDLE;
    end else if (s1_adv) begin
      prefix_r <= prefix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && step.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step.emit) begin
      out_code_r <= step.code;
      out_ret_r  <= step.ret;
      out_bad_r  <= step.bad;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_code    = out_code_r;
  assign out_byte_returned = out_ret_r;
  assign out_bad_byte      = out_bad_r;

endmodule
